// ----- hdl/lcsl_pkg.sv -----
package lcsl_pkg;

    // Default reference capacity (symbols)
    localparam int MAX_LEN_DEF = 256;

    // Result length saturates here
    localparam int LEN_SAT = 511;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 9;
    localparam int M_TDATA_W = 16;

    // Item kind carried on s_tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Control part of a query item moving down the cell chain
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SYM_W-1:0] symbol;
    } tok_ctl_t;

endpackage

// ----- hdl/longest_common_subsequence_length_unit.sv -----
// Longest common subsequence length of two byte strings, built as a systolic
// row of MAX_LEN cells, one per reference symbol. Reference symbols
// (s_tuser = 0) are written straight into the next free cell, one per cycle
// while s_tready is high; symbols beyond MAX_LEN are dropped and flagged as
// overflow. Query symbols (s_tuser = 1) enter the row one per cycle while
// s_tready is high and ripple through it as a wavefront, each cell updating
// its DP value as the item passes. A query item with s_tlast ends the job:
// m_tvalid rises once it has passed every cell register and the result
// register, and s_tready stays low from that acceptance until the result is
// taken on the m_ side, so no new item is taken while the job drains through
// the cell row or while m_tready is held low. The row clears itself behind the
// final item; no clearing pass is needed after reset. tlast on a reference
// symbol is ignored.
module longest_common_subsequence_length_unit #(
    parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // last
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [8:0] lcs_length, [9] overflow, rest zero
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LEN);

    logic                 s_acc, m_acc, is_load, is_query, load_en;
    logic [CNT_W-1:0]     ref_count_reg;
    logic                 ovf_reg, ovf_hold_reg, drain_reg;
    logic                 m_valid_reg;
    logic [lcsl_pkg::LEN_W-1:0] len_reg;
    logic [31:0]          end_wide;
    logic [lcsl_pkg::LEN_W-1:0] end_len;

    lcsl_pkg::tok_ctl_t   tok   [MAX_LEN+1];
    logic [CNT_W-1:0]     tok_n [MAX_LEN+1];
    logic [CNT_W-1:0]     left  [MAX_LEN+1];
    logic [CNT_W-1:0]     diag  [MAX_LEN+1];

    assign s_tready = !drain_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign is_load  = s_acc && (s_tuser == lcsl_pkg::FUNC_LOAD);
    assign is_query = s_acc && (s_tuser == lcsl_pkg::FUNC_QUERY);
    assign load_en  = is_load && (ref_count_reg != FULL_CNT);

    // head of the chain
    assign tok[0].valid  = is_query;
    assign tok[0].last   = s_tlast;
    assign tok[0].symbol = s_tdata;
    assign tok_n[0]      = ref_count_reg;
    assign left[0]       = '0;
    assign diag[0]       = '0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcsl_cell #(
            .MAX_LEN (MAX_LEN),
            .IDX     (g),
            .CNT_W   (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_en),
            .load_idx  (ref_count_reg),
            .load_sym  (s_tdata),
            .tok_in    (tok[g]),
            .tok_n_in  (tok_n[g]),
            .left_in   (left[g]),
            .diag_in   (diag[g]),
            .tok_out   (tok[g+1]),
            .tok_n_out (tok_n[g+1]),
            .left_out  (left[g+1]),
            .diag_out  (diag[g+1])
        );
    end

    // job control: fill count, overflow, drain after final query item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_count_reg <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= 1'b0;
        end else begin
            if (load_en) begin
                ref_count_reg <= ref_count_reg + CNT_W'(1);
            end else if (is_load) begin
                ovf_reg <= 1'b1;
            end
            if (is_query && s_tlast) begin
                ref_count_reg <= '0;
                ovf_reg       <= 1'b0;
                drain_reg     <= 1'b1;
            end else if (m_acc) begin
                drain_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_query && s_tlast) begin
            ovf_hold_reg <= ovf_reg;
        end
    end

    // saturate the length at the end of the chain
    assign end_wide = 32'(left[MAX_LEN]);
    assign end_len  = (end_wide > 32'(lcsl_pkg::LEN_SAT)) ?
                      lcsl_pkg::LEN_W'(lcsl_pkg::LEN_SAT) : end_wide[lcsl_pkg::LEN_W-1:0];

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tok[MAX_LEN].valid && tok[MAX_LEN].last) begin
            m_valid_reg <= 1'b1;
        end else if (m_acc) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok[MAX_LEN].valid && tok[MAX_LEN].last) begin
            len_reg <= end_len;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, ovf_hold_reg, len_reg};

    // a finishing item never lands on a result still waiting
    a_no_result_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok[MAX_LEN].valid && tok[MAX_LEN].last) |-> !m_valid_reg)
        else $error("final item reached chain end with result pending");

    // a result is only held while the block drains its job
    a_result_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> drain_reg)
        else $error("result valid outside drain");

    // fill count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ref_count_reg <= FULL_CNT)
        else $error("reference count past capacity");

    // job state is cleared during drain
    a_drain_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> (ref_count_reg == '0 && !ovf_reg))
        else $error("job state not cleared during drain");

endmodule

// ----- hdl/lcsl_cell.sv -----
module lcsl_cell #(
    parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF,
    parameter int IDX     = 0,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // reference load bus, shared by all cells
    input  logic                      load_en,
    input  logic [CNT_W-1:0]          load_idx,
    input  logic [lcsl_pkg::SYM_W-1:0] load_sym,
    // query item from the left neighbor
    input  lcsl_pkg::tok_ctl_t        tok_in,
    input  logic [CNT_W-1:0]          tok_n_in,
    input  logic [CNT_W-1:0]          left_in,
    input  logic [CNT_W-1:0]          diag_in,
    // query item to the right neighbor
    output lcsl_pkg::tok_ctl_t        tok_out,
    output logic [CNT_W-1:0]          tok_n_out,
    output logic [CNT_W-1:0]          left_out,
    output logic [CNT_W-1:0]          diag_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [lcsl_pkg::SYM_W-1:0] sym_reg;
    logic [CNT_W-1:0]           row_reg, row_next;
    lcsl_pkg::tok_ctl_t         tok_reg;
    logic [CNT_W-1:0]           tok_n_reg, left_reg, diag_reg;
    logic [CNT_W-1:0]           up, cur;
    logic                       load_hit, proc;

    assign load_hit = load_en && (load_idx == MY_IDX);
    // only cells that held a reference symbol when the item entered take part
    assign proc     = tok_in.valid && (tok_n_in > MY_IDX);
    assign up       = row_reg;

    // one DP step: match extends the diagonal, else best of up and left
    always_comb begin
        if (sym_reg == tok_in.symbol) begin
            cur = diag_in + CNT_W'(1);
        end else begin
            cur = (up > left_in) ? up : left_in;
        end
    end

    // row value: new symbol or end of job clears it, else a taking-part item updates it
    always_comb begin
        row_next = row_reg;
        if (load_hit) begin
            row_next = '0;
        end else if (tok_in.valid && tok_in.last) begin
            row_next = '0;
        end else if (proc) begin
            row_next = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            tok_reg <= '0;
        end else begin
            row_reg <= row_next;
            tok_reg <= tok_in;
        end
    end

    // reference symbol and pass-through payload
    always_ff @(posedge aclk) begin
        if (load_hit) begin
            sym_reg <= load_sym;
        end
        tok_n_reg      <= tok_n_in;
        left_reg       <= proc ? cur : left_in;
        diag_reg       <= up;
    end

    assign tok_out   = tok_reg;
    assign tok_n_out = tok_n_reg;
    assign left_out  = left_reg;
    assign diag_out  = diag_reg;

endmodule

// ----- tb/tb_longest_common_subsequence_length_unit.sv -----
module tb_longest_common_subsequence_length_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = lcsl_pkg::MAX_LEN_DEF;
    localparam int ITEM_TARGET = 2000;

    typedef struct packed {
        logic [lcsl_pkg::LEN_W-1:0] lcs_len;
        logic                       ovf;
    } lcs_result_t;

    typedef enum int {PAIR_CLEAN, PAIR_OVERFLOW, PAIR_MIXED, PAIR_NO_REF} pair_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

    // Tracks the DP row of the current string pair and the lengths still owed
    class lcs_scoreboard_t;
        logic [lcsl_pkg::SYM_W-1:0] ref_sym [DEPTH];
        logic [lcsl_pkg::LEN_W-1:0] dp_row [DEPTH];
        int               ref_cnt;
        logic             ovf;
        lcs_result_t      owed_lengths[$];
        int               mismatches;
        int               results_seen;

        function new();
            ref_cnt = 0;
            ovf = 1'b0;
            mismatches = 0;
            results_seen = 0;
            foreach (ref_sym[j]) ref_sym[j] = '0;
            foreach (dp_row[j]) dp_row[j] = '0;
        endfunction

        function int pending();
            return owed_lengths.size();
        endfunction

        // Apply one accepted item to the row; a final query owes a result
        function void note_symbol(logic func, logic [lcsl_pkg::SYM_W-1:0] sym, logic lst);
            logic [lcsl_pkg::LEN_W-1:0] diag, left, up, cur;
            lcs_result_t      res;
            int               len;
            if (func == lcsl_pkg::FUNC_LOAD) begin
                if (ref_cnt < DEPTH) begin
                    ref_sym[ref_cnt] = sym;
                    dp_row[ref_cnt] = '0;
                    ref_cnt++;
                end else begin
                    ovf = 1'b1;
                end
                return;
            end
            diag = '0;
            left = '0;
            for (int j = 0; j < ref_cnt; j++) begin
                up = dp_row[j];
                if (ref_sym[j] == sym)
                    cur = diag + 1'b1;
                else
                    cur = (up > left) ? up : left;
                dp_row[j] = cur;
                diag = up;
                left = cur;
            end
            if (!lst)
                return;
            len = (ref_cnt == 0) ? 0 : int'(dp_row[ref_cnt-1]);
            if (len > lcsl_pkg::LEN_SAT)
                len = lcsl_pkg::LEN_SAT;
            res.lcs_len = len[lcsl_pkg::LEN_W-1:0];
            res.ovf = ovf;
            owed_lengths.push_back(res);
            // job done: row, count and flag go back to reset, symbols stay
            ref_cnt = 0;
            ovf = 1'b0;
            foreach (dp_row[j]) dp_row[j] = '0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
            mismatches++;
        endtask

        task check_length(logic [lcsl_pkg::M_TDATA_W-1:0] data);
            lcs_result_t want;
            results_seen++;
            if (owed_lengths.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%04h", data));
                return;
            end
            want = owed_lengths.pop_front();
            if (data[lcsl_pkg::LEN_W-1:0] !== want.lcs_len)
                report_mismatch($sformatf("lcs_length %0d, want %0d",
                                          data[lcsl_pkg::LEN_W-1:0], want.lcs_len));
            if (data[lcsl_pkg::LEN_W] !== want.ovf)
                report_mismatch($sformatf("overflow %b, want %b",
                                          data[lcsl_pkg::LEN_W], want.ovf));
            if (data[lcsl_pkg::M_TDATA_W-1:lcsl_pkg::LEN_W+1] !== '0)
                report_mismatch($sformatf("pad bits 0x%0h, want 0",
                                          data[lcsl_pkg::M_TDATA_W-1:lcsl_pkg::LEN_W+1]));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [lcsl_pkg::M_TDATA_W-1:0] m_tdata;

    lcs_scoreboard_t sb = new();
    int            burst_left = 0;
    int            items_sent = 0;
    rx_mode_t      rx_mode = RX_OPEN;
    int            rx_hold = 0;
    logic [2:0]    rx_beat = '0;

    longest_common_subsequence_length_unit #(
        .MAX_LEN(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watch both channels; results are checked before the input of the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_length(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_symbol(s_tuser, s_tdata, s_tlast);
        end
    end

    // Receiver stalls: each mode is held for a random stretch, then a new one is drawn
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 200);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        rx_beat <= rx_beat + 1'b1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= (rx_beat[1:0] != 2'd0);
        endcase
    end

    // One item; the sender runs in bursts with idle gaps between them
    task automatic send_symbol(logic func, logic [7:0] sym, logic lst);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= sym;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // Hold off until every owed result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_symbol(logic [7:0] base, int span);
        if (span == 0)
            return 8'($urandom_range(0, 255));
        return base + 8'($urandom_range(0, span - 1));
    endfunction

    // One reference/query pair of the given shape
    task automatic run_pair(pair_kind_t kind);
        logic [7:0] base;
        int         span, ref_len, qry_len, total;
        logic       func;
        base = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 1;
            2:       span = 2;
            default: span = 4;
        endcase
        case (kind)
            PAIR_CLEAN: begin
                if ($urandom_range(0, 39) == 0)
                    ref_len = DEPTH;
                else if ($urandom_range(0, 29) == 0)
                    ref_len = $urandom_range(100, DEPTH);
                else
                    ref_len = $urandom_range(1, 16);
                qry_len = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(1, 16);
                repeat (ref_len)
                    send_symbol(lcsl_pkg::FUNC_LOAD, pick_symbol(base, span), 1'b0);
                for (int i = 1; i <= qry_len; i++)
                    send_symbol(lcsl_pkg::FUNC_QUERY, pick_symbol(base, span),
                                i == qry_len);
            end
            PAIR_OVERFLOW: begin
                // fill the store, then drop a few more
                ref_len = DEPTH + $urandom_range(1, 8);
                qry_len = $urandom_range(1, 8);
                repeat (ref_len)
                    send_symbol(lcsl_pkg::FUNC_LOAD, pick_symbol(base, span),
                                ($urandom_range(0, 15) == 0));
                for (int i = 1; i <= qry_len; i++)
                    send_symbol(lcsl_pkg::FUNC_QUERY, pick_symbol(base, span),
                                i == qry_len);
            end
            PAIR_MIXED: begin
                // loads and queries interleaved, stray last marks on loads
                total = $urandom_range(2, 24);
                for (int i = 1; i < total; i++) begin
                    func = 1'($urandom_range(0, 1));
                    send_symbol(func, pick_symbol(base, span),
                                (func == lcsl_pkg::FUNC_LOAD) && ($urandom_range(0, 2) == 0));
                end
                send_symbol(lcsl_pkg::FUNC_QUERY, pick_symbol(base, span), 1'b1);
            end
            default: begin
                qry_len = $urandom_range(1, 4);
                for (int i = 1; i <= qry_len; i++)
                    send_symbol(lcsl_pkg::FUNC_QUERY, pick_symbol(base, span),
                                i == qry_len);
            end
        endcase
    endtask

    initial begin
        pair_kind_t kind;
        int         roll;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty reference: length 0
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h00, 1'b1);
        // byte extremes; last on a load is ignored
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'h00, 1'b0);
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'hFF, 1'b1);
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'hA5, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'hFF, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'hA5, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h5A, 1'b1);
        // load appended after a query has been seen
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'h11, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h11, 1'b0);
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'h22, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h22, 1'b1);
        // single match
        send_symbol(lcsl_pkg::FUNC_LOAD, 8'h80, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h80, 1'b1);
        // repeated symbol on both sides
        repeat (3) send_symbol(lcsl_pkg::FUNC_LOAD, 8'h7F, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h7F, 1'b0);
        send_symbol(lcsl_pkg::FUNC_QUERY, 8'h7F, 1'b1);
        drain_results();

        // random pairs, the first one always overflows
        kind = PAIR_OVERFLOW;
        while (items_sent < ITEM_TARGET) begin
            run_pair(kind);
            if ($urandom_range(0, 9) == 0)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                kind = PAIR_OVERFLOW;
            else if (roll < 25)
                kind = PAIR_MIXED;
            else if (roll < 32)
                kind = PAIR_NO_REF;
            else
                kind = PAIR_CLEAN;
        end

        drain_results();
        repeat (DEPTH + 16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
